@@ hw/rtl/cmsc_pkg.sv @@
// Package: shared types, constants and command/status structs for the mult/shift calculator.
package cmsc_pkg;

  localparam logic [31:0] NS_PER_SEC     = 32'd1000000000;
  localparam logic [31:0] SPAN_CAP       = 32'd600;
  localparam logic [31:0] MIN_MARGIN     = 32'd200000;
  localparam logic [31:0] DEFAULT_MARGIN = NS_PER_SEC >> 5;
  localparam logic [5:0]  SHIFT_TOP      = 6'd32;

  // datapath operations, issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // latch request, clear flags
    OP_DIV1,      // quot = mask / freq
    OP_DIV2,      // quot = quot / scale
    OP_DIV3,      // to = 1e9 / scale
    OP_SPAN,      // clamp seconds, maxsec = sec * scale (low 32)
    OP_MUL,       // prod = (maxsec * freq) >> 32
    OP_ACC,       // one step of headroom count
    OP_DIVS,      // t = ((to << s) + freq/2) / freq
    OP_CHKS,      // test t >> acc, step s
    OP_PRODM,     // prod = scale * freq (low 32)
    OP_DIVM,      // margin = 1e9 / prod
    OP_ADJ,       // q = mult / 100 by reciprocal, adj from q and remainder next
    OP_ADJ2,
    OP_HALVE
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic freq_zero;
    logic scale_zero;
    logic given_zero;
    logic prod_zero;
    logic t_zero;       // headroom count done
    logic fits;         // t >> acc == 0
    logic s_zero;       // shift search at 0 after step
    logic ovf;          // mult + adj overflows
    logic shift_zero;
  } dp_sts_t;

  typedef enum logic [18:0] {
    S_IDLE  = 19'b0000000000000000001,
    S_LOAD  = 19'b0000000000000000010,
    S_DIV1  = 19'b0000000000000000100,
    S_DIV2  = 19'b0000000000000001000,
    S_DIV3  = 19'b0000000000000010000,
    S_SPAN  = 19'b0000000000000100000,
    S_MUL   = 19'b0000000000001000000,
    S_ACC   = 19'b0000000000010000000,
    S_DIVS  = 19'b0000000000100000000,
    S_CHKS  = 19'b0000000001000000000,
    S_PRODM = 19'b0000000010000000000,
    S_DIVM  = 19'b0000000100000000000,
    S_ADJ   = 19'b0000001000000000000,
    S_ADJ2  = 19'b0000010000000000000,
    S_OVF   = 19'b0000100000000000000,
    S_DONE  = 19'b0001000000000000000,
    S_WAIT  = 19'b0010000000000000000,
    S_WAITM = 19'b0100000000000000000,
    S_WAITS = 19'b1000000000000000000
  } state_t;

endpackage

@@ hw/rtl/cmsc_div.sv @@
// Bit-serial restoring divider, 65-bit dividend by 64-bit divisor, one bit per cycle.
module cmsc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [64:0] dividend,
  input  logic [63:0] divisor,
  output logic        busy,
  output logic [64:0] quot
);

  logic [64:0] q_r, q_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] dv_r, dv_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [65:0] trial;

  assign trial = {rem_r, q_r[64]} - {2'b00, dv_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (go) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dv_nxt   = divisor;
      cnt_nxt  = 7'd65;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[65]) begin
        rem_nxt = trial[64:0];
        q_nxt   = {q_r[63:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[63:0], q_r[64]};
        q_nxt   = {q_r[63:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

@@ hw/rtl/cmsc_datapath.sv @@
// Datapath: operand registers, shared serial divider, multiplier and result registers.
module cmsc_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  cmsc_pkg::dp_cmd_t  cmd,
  input  logic               set_err,
  output cmsc_pkg::dp_sts_t  sts,
  input  logic [63:0]        in_counter_mask,
  input  logic [31:0]        in_freq,
  input  logic [31:0]        in_scale,
  input  logic [31:0]        in_current_mult,
  input  logic [5:0]         in_current_shift,
  input  logic [31:0]        in_given_margin,
  output logic [31:0]        mult,
  output logic [5:0]         shift,
  output logic [28:0]        max_adjust,
  output logic [31:0]        margin,
  output logic               error
);

  logic [63:0] mask_r;
  logic [31:0] freq_r, scale_r, given_r;
  logic [64:0] quot_r;     // seconds span, then t
  logic [31:0] to_r, maxsec_r, prod32_r;
  logic [63:0] prod_r;
  logic [5:0]  acc_r, s_r;
  logic [31:0] mult_r, margin_r;
  logic [5:0]  shift_r;
  logic [25:0] q100_r;
  logic [28:0] adj_r;
  logic        err_r;

  logic        div_go, div_busy;
  logic [64:0] div_a, div_q;
  logic [63:0] div_b;
  logic [63:0] sec;
  logic [32:0] sum;
  logic [62:0] recip;
  logic [6:0]  rem_w;
  logic [22:0] frac_p;
  logic [28:0] adj_w;

  cmsc_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .quot(div_q)
  );

  always_comb begin
    div_go = 1'b0;
    div_a  = '0;
    div_b  = 64'd1;
    unique case (cmd.op)
      cmsc_pkg::OP_DIV1: begin
        div_go = 1'b1; div_a = {1'b0, mask_r}; div_b = {32'd0, freq_r};
      end
      cmsc_pkg::OP_DIV2: begin
        div_go = 1'b1; div_a = quot_r; div_b = {32'd0, scale_r};
      end
      cmsc_pkg::OP_DIV3: begin
        div_go = 1'b1; div_a = {33'd0, cmsc_pkg::NS_PER_SEC}; div_b = {32'd0, scale_r};
      end
      cmsc_pkg::OP_DIVS: begin
        div_go = 1'b1;
        div_a  = ({33'd0, to_r} << s_r) + {34'd0, freq_r[31:1]};
        div_b  = {32'd0, freq_r};
      end
      cmsc_pkg::OP_DIVM: begin
        div_go = 1'b1; div_a = {33'd0, cmsc_pkg::NS_PER_SEC}; div_b = {32'd0, prod32_r};
      end
      default: ;
    endcase
  end

  always_comb begin
    sec = quot_r[63:0];
    if (sec == 64'd0) sec = 64'd1;
    else if (sec > {32'd0, cmsc_pkg::SPAN_CAP} && mask_r[63:32] != 32'd0)
      sec = {32'd0, cmsc_pkg::SPAN_CAP};
  end

  assign sum = {1'b0, mult_r} + {4'd0, adj_r};

  // mult / 100 by reciprocal, exact over 32 bits; 11% = 11q + 11r/100
  assign recip  = {31'd0, mult_r} * 63'd1374389535;
  assign rem_w  = mult_r[6:0] - (q100_r[6:0] * 7'd100);
  assign frac_p = {16'd0, rem_w} * 23'd57673;
  assign adj_w  = ({3'd0, q100_r} * 29'd11) + {25'd0, frac_p[22:19]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r <= 1'b0;
    end else begin
      if (cmd.op == cmsc_pkg::OP_LOAD) err_r <= 1'b0;
      else if (set_err) err_r <= 1'b1;
    end
    unique case (cmd.op)
      cmsc_pkg::OP_LOAD: begin
        mask_r  <= in_counter_mask;
        freq_r  <= in_freq;
        scale_r <= in_scale;
        given_r <= in_given_margin;
        mult_r  <= in_current_mult;
        shift_r <= in_current_shift;
        acc_r   <= cmsc_pkg::SHIFT_TOP;
        s_r     <= cmsc_pkg::SHIFT_TOP;
        margin_r <= (in_given_margin != 32'd0) ? in_given_margin : cmsc_pkg::DEFAULT_MARGIN;
      end
      cmsc_pkg::OP_SPAN: maxsec_r <= sec[31:0] * scale_r;
      cmsc_pkg::OP_MUL:  prod_r <= ({32'd0, maxsec_r} * {32'd0, freq_r}) >> 32;
      cmsc_pkg::OP_ACC: begin
        prod_r <= prod_r >> 1;
        acc_r  <= acc_r - 6'd1;
      end
      cmsc_pkg::OP_CHKS: begin
        mult_r  <= quot_r[31:0];
        // search exhausted leaves shift 0 with the multiplier from shift 1
        shift_r <= sts.fits ? s_r : s_r - 6'd1;
        s_r     <= s_r - 6'd1;
      end
      cmsc_pkg::OP_PRODM: prod32_r <= scale_r * freq_r;
      cmsc_pkg::OP_ADJ:   q100_r <= recip[62:37];
      cmsc_pkg::OP_ADJ2:  adj_r <= adj_w;
      cmsc_pkg::OP_HALVE: begin
        mult_r  <= mult_r >> 1;
        shift_r <= shift_r - 6'd1;
      end
      default: ;
    endcase
    // capture divider results while it is idle after a run
    if (!div_busy) begin
      quot_r <= div_q;
      if (cmd.op == cmsc_pkg::OP_MUL) to_r <= div_q[31:0];
      if (cmd.op == cmsc_pkg::OP_ADJ && given_r == 32'd0 && prod32_r != 32'd0
          && freq_r != 32'd0 && scale_r != 32'd0)
        margin_r <= (div_q[31:0] < cmsc_pkg::MIN_MARGIN) ? cmsc_pkg::MIN_MARGIN
                                                          : div_q[31:0];
    end
  end

  always_comb begin
    sts.div_busy   = div_busy | div_go;
    sts.freq_zero  = (freq_r == 32'd0);
    sts.scale_zero = (scale_r == 32'd0);
    sts.given_zero = (given_r == 32'd0);
    sts.prod_zero  = (prod32_r == 32'd0);
    sts.t_zero     = (prod_r == 64'd0);
    sts.fits       = ((div_q >> acc_r) == 65'd0);
    sts.s_zero     = (s_r == 6'd1);
    sts.ovf        = sum[32];
    sts.shift_zero = (shift_r == 6'd0);
  end

  assign error      = err_r;
  assign mult       = err_r ? 32'd0 : mult_r;
  assign shift      = err_r ? 6'd0 : shift_r;
  assign max_adjust = err_r ? 29'd0 : adj_r;
  assign margin     = err_r ? 32'd0 : margin_r;

endmodule

@@ hw/rtl/cmsc_ctrl.sv @@
// Controller: sequences the span, shift search, margin and halving steps.
module cmsc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  cmsc_pkg::dp_sts_t sts,
  output cmsc_pkg::dp_cmd_t cmd,
  output logic              set_err,
  output logic              busy,
  output logic              done
);

  cmsc_pkg::state_t st_r, st_nxt, ret_r, ret_nxt;

  always_comb begin
    st_nxt  = st_r;
    ret_nxt = ret_r;
    cmd.op  = cmsc_pkg::OP_NONE;
    set_err = 1'b0;
    unique case (st_r)
      cmsc_pkg::S_IDLE: if (start) begin
        cmd.op = cmsc_pkg::OP_LOAD; st_nxt = cmsc_pkg::S_LOAD;
      end
      cmsc_pkg::S_LOAD: begin
        if (sts.freq_zero) st_nxt = cmsc_pkg::S_PRODM;
        else if (sts.scale_zero) begin
          set_err = 1'b1; st_nxt = cmsc_pkg::S_PRODM;
        end else begin
          cmd.op = cmsc_pkg::OP_DIV1; st_nxt = cmsc_pkg::S_WAIT;
          ret_nxt = cmsc_pkg::S_DIV2;
        end
      end
      cmsc_pkg::S_WAIT: if (!sts.div_busy) st_nxt = ret_r;
      cmsc_pkg::S_DIV2: begin
        cmd.op = cmsc_pkg::OP_DIV2; st_nxt = cmsc_pkg::S_WAIT; ret_nxt = cmsc_pkg::S_DIV3;
      end
      cmsc_pkg::S_DIV3: begin
        // quotient (seconds) is held until SPAN via the idle-capture, so snapshot first
        cmd.op = cmsc_pkg::OP_SPAN; st_nxt = cmsc_pkg::S_SPAN;
      end
      cmsc_pkg::S_SPAN: begin
        cmd.op = cmsc_pkg::OP_DIV3; st_nxt = cmsc_pkg::S_WAIT; ret_nxt = cmsc_pkg::S_MUL;
      end
      cmsc_pkg::S_MUL: begin
        // also takes 1e9 / scale from the divider
        cmd.op = cmsc_pkg::OP_MUL; st_nxt = cmsc_pkg::S_ACC;
      end
      cmsc_pkg::S_ACC: begin
        if (!sts.t_zero) cmd.op = cmsc_pkg::OP_ACC;
        else st_nxt = cmsc_pkg::S_DIVS;
      end
      cmsc_pkg::S_DIVS: begin
        cmd.op = cmsc_pkg::OP_DIVS; st_nxt = cmsc_pkg::S_WAITS;
      end
      cmsc_pkg::S_WAITS: if (!sts.div_busy) st_nxt = cmsc_pkg::S_CHKS;
      cmsc_pkg::S_CHKS: begin
        cmd.op = cmsc_pkg::OP_CHKS;
        if (sts.fits) st_nxt = cmsc_pkg::S_PRODM;
        else if (sts.s_zero) st_nxt = cmsc_pkg::S_WAITM; // exhausted: shift 0
        else st_nxt = cmsc_pkg::S_DIVS;
      end
      cmsc_pkg::S_WAITM: begin
        // CHKS has recorded shift 0 with the shift-1 multiplier
        st_nxt = cmsc_pkg::S_PRODM;
      end
      cmsc_pkg::S_PRODM: begin
        cmd.op = cmsc_pkg::OP_PRODM; st_nxt = cmsc_pkg::S_DIVM;
      end
      cmsc_pkg::S_DIVM: begin
        if (sts.given_zero && !sts.freq_zero && !sts.scale_zero) begin
          if (sts.prod_zero) begin
            set_err = 1'b1; st_nxt = cmsc_pkg::S_ADJ;
          end else begin
            cmd.op = cmsc_pkg::OP_DIVM; st_nxt = cmsc_pkg::S_WAIT;
            ret_nxt = cmsc_pkg::S_ADJ;
          end
        end else st_nxt = cmsc_pkg::S_ADJ;
      end
      cmsc_pkg::S_ADJ: begin
        cmd.op = cmsc_pkg::OP_ADJ; st_nxt = cmsc_pkg::S_ADJ2;
      end
      cmsc_pkg::S_ADJ2: begin
        cmd.op = cmsc_pkg::OP_ADJ2; st_nxt = cmsc_pkg::S_OVF;
      end
      cmsc_pkg::S_OVF: begin
        if (!sts.freq_zero && sts.ovf) begin
          if (sts.shift_zero) begin
            set_err = 1'b1; st_nxt = cmsc_pkg::S_DONE;
          end else begin
            cmd.op = cmsc_pkg::OP_HALVE; st_nxt = cmsc_pkg::S_ADJ;
          end
        end else st_nxt = cmsc_pkg::S_DONE;
      end
      cmsc_pkg::S_DONE: st_nxt = cmsc_pkg::S_IDLE;
      default: st_nxt = cmsc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= cmsc_pkg::S_IDLE;
      ret_r <= cmsc_pkg::S_IDLE;
    end else begin
      st_r  <= st_nxt;
      ret_r <= ret_nxt;
    end
  end

  assign busy = (st_r != cmsc_pkg::S_IDLE);
  assign done = (st_r == cmsc_pkg::S_DONE);

endmodule

@@ hw/rtl/clock_mult_shift_calc.sv @@
// Top level of the clock multiplier/shift calculator.
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  input   | start, busy         | in_counter_mask, in_freq, in_scale, in_current_*
//  result  | out_valid (strobe)  | out_mult, out_shift, out_max_adjust, out_margin_ns, ...
//
// One request at a time. With freq nonzero: up to 36 runs of the serial divider,
// each with issue and hand-off; the shift search makes up to 32 of them, and each
// halving step repeats the adjust steps. With freq zero the divider is not run.
// Synchronous reset returns the controller to idle. The result strobe lasts
// one cycle; the receiver cannot stall, busy drops the cycle after.
module clock_mult_shift_calc (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_counter_mask,
  input  logic [31:0] in_freq,
  input  logic [31:0] in_scale,
  input  logic [31:0] in_current_mult,
  input  logic [5:0]  in_current_shift,
  input  logic [31:0] in_given_margin,
  output logic        out_valid,
  output logic [31:0] out_mult,
  output logic [5:0]  out_shift,
  output logic [28:0] out_max_adjust,
  output logic [31:0] out_margin_ns,
  output logic        out_error
);

  cmsc_pkg::dp_cmd_t cmd;
  cmsc_pkg::dp_sts_t sts;
  logic set_err;

  cmsc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .cmd(cmd),
    .set_err(set_err), .busy(busy), .done(out_valid)
  );

  cmsc_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .set_err(set_err), .sts(sts),
    .in_counter_mask(in_counter_mask), .in_freq(in_freq), .in_scale(in_scale),
    .in_current_mult(in_current_mult), .in_current_shift(in_current_shift),
    .in_given_margin(in_given_margin),
    .mult(out_mult), .shift(out_shift), .max_adjust(out_max_adjust),
    .margin(out_margin_ns), .error(out_error)
  );

endmodule

@@ hw/rtl/cmsc_checker.sv @@
// Port-level checker for the calculator, bound to the top level.
module cmsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_mult,
  input logic [5:0]  out_shift,
  input logic [28:0] out_max_adjust,
  input logic        out_error
);

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request not taken");
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("strobe while idle");
  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy) else $error("strobe too long");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_mult == 32'd0 && out_shift == 6'd0
    && out_max_adjust == 29'd0) else $error("error result not cleared");

endmodule

bind clock_mult_shift_calc cmsc_checker u_cmsc_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_mult(out_mult), .out_shift(out_shift), .out_max_adjust(out_max_adjust),
  .out_error(out_error)
);
